/* rtl/kex_pkg.sv */
// ----------------------------------------------------------------------------
// kex_pkg
// Shared types and codes for the keyed expiring entry table.
// ----------------------------------------------------------------------------
package kex_pkg;

  // function codes of an input word
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_PURGE = 2'd1;
  localparam logic [1:0] FN_FIRST = 2'd2;
  localparam logic [1:0] FN_NEXT  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_RMV   = 3'd2;
  localparam logic [2:0] ST_IGN   = 3'd3;
  localparam logic [2:0] ST_RET   = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_PURGE = 3'd6;

  // sources for the walk pointer
  localparam logic [2:0] CS_NEWEST = 3'd0;
  localparam logic [2:0] CS_OLDER  = 3'd1;
  localparam logic [2:0] CS_OLDEST = 3'd2;
  localparam logic [2:0] CS_CURSOR = 3'd3;
  localparam logic [2:0] CS_FREEQ  = 3'd4;

  // sources for the iteration cursor
  localparam logic [1:0] KS_NEWEST = 2'd0;
  localparam logic [1:0] KS_OLDER  = 2'd1;
  localparam logic [1:0] KS_NIL    = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] name_key;
    logic [31:0] data_tag;
    logic [31:0] expiry_time;
    logic        discard_mark;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        evicted_oldest;
    logic [31:0] out_key;
    logic [31:0] out_tag;
    logic [6:0]  entry_count;
    logic [31:0] total_cached;
    logic [31:0] updated_total;
    logic [31:0] purged_fresh;
    logic [31:0] purged_stale;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       cur_ld;
    logic [2:0] cur_src;
    logic       cursor_ld;
    logic [1:0] cursor_src;
    logic       rd;
    logic       unlink;
    logic       free_slot;
    logic       cnt_purge;
    logic       cnt_in;
    logic       evict_set;
    logic       alloc;
    logic       push_a;
    logic       push_b;
    logic       upd_inc;
    logic       cached_inc;
    logic       res_ld;
    logic [2:0] res_status;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       stale_in;
    logic       cur_nil;
    logic       cursor_nil;
    logic       key_hit;
    logic       slot_stale;
    logic       slot_discardable;
    logic       evict_need;
    logic       fill_avail;
    logic       out_free;
  } sts_t;

endpackage

/* rtl/kex_ram.sv */
// ----------------------------------------------------------------------------
// kex_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/kex_ctrl.sv */
// ----------------------------------------------------------------------------
// kex_ctrl
// Sequencer: walks the entry list and issues datapath commands per word.
// ----------------------------------------------------------------------------
module kex_ctrl
  import kex_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_SRD    = 5'd2;
  localparam logic [4:0] S_SCHK   = 5'd3;
  localparam logic [4:0] S_EVC    = 5'd4;
  localparam logic [4:0] S_ERD    = 5'd5;
  localparam logic [4:0] S_EUNL   = 5'd6;
  localparam logic [4:0] S_ALLOC  = 5'd7;
  localparam logic [4:0] S_ALLOC2 = 5'd8;
  localparam logic [4:0] S_PUSHA  = 5'd9;
  localparam logic [4:0] S_PUSHB  = 5'd10;
  localparam logic [4:0] S_PRD    = 5'd11;
  localparam logic [4:0] S_PCHK   = 5'd12;
  localparam logic [4:0] S_IRD    = 5'd13;
  localparam logic [4:0] S_INXT   = 5'd14;
  localparam logic [4:0] S_YRD    = 5'd15;
  localparam logic [4:0] S_YR2    = 5'd16;
  localparam logic [4:0] S_YCHK   = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       upd_r, upd_nxt;

  always_comb begin
    state_nxt = state_r;
    upd_nxt   = upd_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        upd_nxt = 1'b0;
        unique case (sts.func)
          FN_ADD: begin
            cmd.cur_ld  = 1'b1;
            cmd.cur_src = CS_NEWEST;
            state_nxt   = S_SRD;
          end
          FN_PURGE: begin
            cmd.cur_ld  = 1'b1;
            cmd.cur_src = CS_NEWEST;
            state_nxt   = S_PRD;
          end
          FN_FIRST: begin
            cmd.cursor_ld  = 1'b1;
            cmd.cursor_src = KS_NEWEST;
            state_nxt      = S_YRD;
          end
          FN_NEXT: begin
            if (sts.cursor_nil) begin
              state_nxt = S_YRD;
            end else begin
              cmd.cur_ld  = 1'b1;
              cmd.cur_src = CS_CURSOR;
              state_nxt   = S_IRD;
            end
          end
        endcase
      end
      S_SRD: begin
        if (sts.cur_nil) begin
          if (sts.stale_in) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_IGN;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_EVC;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts.key_hit) begin
          cmd.unlink = 1'b1;
          if (sts.stale_in) begin
            cmd.free_slot  = 1'b1;
            cmd.cnt_purge  = 1'b1;
            cmd.cnt_in     = 1'b1;
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_RMV;
            state_nxt      = S_DONE;
          end else begin
            // reuse the slot in place, move it to the front
            upd_nxt   = 1'b1;
            state_nxt = S_PUSHA;
          end
        end else begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_src = CS_OLDER;
          state_nxt   = S_SRD;
        end
      end
      S_EVC: begin
        if (sts.evict_need) begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_src = CS_OLDEST;
          state_nxt   = S_ERD;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ERD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EUNL;
      end
      S_EUNL: begin
        cmd.unlink    = 1'b1;
        cmd.free_slot = 1'b1;
        cmd.cnt_purge = 1'b1;
        cmd.evict_set = 1'b1;
        state_nxt     = S_EVC;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.fill_avail ? S_PUSHA : S_ALLOC2;
      end
      S_ALLOC2: begin
        cmd.cur_ld  = 1'b1;
        cmd.cur_src = CS_FREEQ;
        state_nxt   = S_PUSHA;
      end
      S_PUSHA: begin
        cmd.push_a = 1'b1;
        state_nxt  = S_PUSHB;
      end
      S_PUSHB: begin
        cmd.push_b = 1'b1;
        cmd.res_ld = 1'b1;
        if (upd_r) begin
          cmd.upd_inc    = 1'b1;
          cmd.res_status = ST_UPD;
        end else begin
          cmd.cached_inc = 1'b1;
          cmd.res_status = ST_NEW;
        end
        state_nxt = S_DONE;
      end
      S_PRD: begin
        if (sts.cur_nil) begin
          cmd.cursor_ld  = 1'b1;
          cmd.cursor_src = KS_NIL;
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_PURGE;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        cmd.cur_ld  = 1'b1;
        cmd.cur_src = CS_OLDER;
        if (sts.slot_discardable) begin
          cmd.unlink    = 1'b1;
          cmd.free_slot = 1'b1;
          cmd.cnt_purge = 1'b1;
        end
        state_nxt = S_PRD;
      end
      S_IRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_INXT;
      end
      S_INXT: begin
        cmd.cursor_ld  = 1'b1;
        cmd.cursor_src = KS_OLDER;
        state_nxt      = S_YRD;
      end
      S_YRD: begin
        if (sts.cursor_nil) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_END;
          state_nxt      = S_DONE;
        end else begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_src = CS_CURSOR;
          state_nxt   = S_YR2;
        end
      end
      S_YR2: begin
        cmd.rd    = 1'b1;
        state_nxt = S_YCHK;
      end
      S_YCHK: begin
        if (sts.slot_stale) begin
          // drop the stale entry, cursor moves to its older neighbor
          cmd.unlink    = 1'b1;
          cmd.free_slot = 1'b1;
          cmd.cnt_purge = 1'b1;
          state_nxt     = S_YRD;
        end else begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_RET;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      upd_r   <= upd_nxt;
    end
  end

endmodule

/* rtl/kex_datapath.sv */
// ----------------------------------------------------------------------------
// kex_datapath
// Entry stores, list pointers, counters and the output register.
// ----------------------------------------------------------------------------
module kex_datapath
  import kex_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  in_t        in_data,
  input  logic       out_ready,
  output logic       out_valid,
  output out_t       out_data,
  input  cmd_t       cmd,
  output sts_t       sts
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int PW = KW + 65;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  in_t          item_r, item_nxt;
  logic [6:0]   limit_r, limit_nxt;
  logic [IW-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [IW-1:0] cursor_r, cursor_nxt, cur_r, cur_nxt;
  logic [IW-1:0] fill_r, fill_nxt, sp_r, sp_nxt, held_r, held_nxt;
  logic [31:0]  cached_r, cached_nxt, upd_r, upd_nxt;
  logic [31:0]  fresh_r, fresh_nxt, stale_r, stale_nxt;
  logic [2:0]   rstat_r, rstat_nxt;
  logic         ev_r, ev_nxt;
  logic [31:0]  rkey_r, rkey_nxt, rtag_r, rtag_nxt;
  out_t         out_r, out_nxt;
  logic         ov_r, ov_nxt;

  logic [PW-1:0] pay_q;
  logic [IW-1:0] older_q, newer_q, free_q;
  logic [KW-1:0] q_key;
  logic [31:0]   q_tag, q_exp, cnt_exp, lim_eff;
  logic          q_disc, stale_in, slot_stale, cnt_stale;

  logic          old_we, new_we;
  logic [AW-1:0] old_wa, new_wa;
  logic [IW-1:0] old_wd, new_wd;
  logic [IW-1:0] sp_dec;

  assign q_key  = pay_q[PW-1 -: KW];
  assign q_tag  = pay_q[64:33];
  assign q_exp  = pay_q[32:1];
  assign q_disc = pay_q[0];
  assign sp_dec = sp_r - IW'(1);

  assign stale_in   = (item_r.expiry_time != '0) && (item_r.expiry_time <= item_r.now_time);
  assign slot_stale = (q_exp != '0) && (q_exp <= item_r.now_time);
  assign cnt_exp    = cmd.cnt_in ? item_r.expiry_time : q_exp;
  assign cnt_stale  = (cnt_exp != '0) && (cnt_exp <= item_r.now_time);
  assign lim_eff    = (limit_r == '0 || 32'(limit_r) > 32'(CAPACITY)) ?
                      32'(CAPACITY) : 32'(limit_r);

  always_comb begin
    sts.func             = item_r.func;
    sts.stale_in         = stale_in;
    sts.cur_nil          = (cur_r == NIL);
    sts.cursor_nil       = (cursor_r == NIL);
    sts.key_hit          = (q_key == item_r.name_key[KW-1:0]);
    sts.slot_stale       = slot_stale;
    sts.slot_discardable = q_disc || (q_exp == '0) || slot_stale;
    sts.evict_need       = (32'(held_r) >= lim_eff) && (oldest_r != NIL);
    sts.fill_avail       = (fill_r != NIL);
    sts.out_free         = !ov_r || out_ready;
  end

  // link store write ports: unlink and push never overlap
  always_comb begin
    old_we = 1'b0;
    old_wa = cur_r[AW-1:0];
    old_wd = newest_r;
    new_we = 1'b0;
    new_wa = cur_r[AW-1:0];
    new_wd = NIL;
    if (cmd.unlink) begin
      old_we = (newer_q != NIL);
      old_wa = newer_q[AW-1:0];
      old_wd = older_q;
      new_we = (older_q != NIL);
      new_wa = older_q[AW-1:0];
      new_wd = newer_q;
    end else if (cmd.push_a) begin
      old_we = 1'b1;
      new_we = 1'b1;
    end else if (cmd.push_b) begin
      new_we = (newest_r != NIL);
      new_wa = newest_r[AW-1:0];
      new_wd = cur_r;
    end
  end

  kex_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_pay (
    .clk   (clk),
    .we    (cmd.push_a),
    .waddr (cur_r[AW-1:0]),
    .wdata ({item_r.name_key[KW-1:0], item_r.data_tag, item_r.expiry_time,
             item_r.discard_mark}),
    .re    (cmd.rd),
    .raddr (cur_r[AW-1:0]),
    .rdata (pay_q)
  );

  kex_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_older (
    .clk   (clk),
    .we    (old_we),
    .waddr (old_wa),
    .wdata (old_wd),
    .re    (cmd.rd),
    .raddr (cur_r[AW-1:0]),
    .rdata (older_q)
  );

  kex_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_newer (
    .clk   (clk),
    .we    (new_we),
    .waddr (new_wa),
    .wdata (new_wd),
    .re    (cmd.rd),
    .raddr (cur_r[AW-1:0]),
    .rdata (newer_q)
  );

  // stack of released slots
  kex_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
    .clk   (clk),
    .we    (cmd.unlink && cmd.free_slot),
    .waddr (sp_r[AW-1:0]),
    .wdata (cur_r),
    .re    (cmd.alloc && !sts.fill_avail),
    .raddr (sp_dec[AW-1:0]),
    .rdata (free_q)
  );

  always_comb begin
    item_nxt   = item_r;
    limit_nxt  = limit_r;
    newest_nxt = newest_r;
    oldest_nxt = oldest_r;
    cursor_nxt = cursor_r;
    cur_nxt    = cur_r;
    fill_nxt   = fill_r;
    sp_nxt     = sp_r;
    held_nxt   = held_r;
    cached_nxt = cached_r;
    upd_nxt    = upd_r;
    fresh_nxt  = fresh_r;
    stale_nxt  = stale_r;
    rstat_nxt  = rstat_r;
    ev_nxt     = ev_r;
    rkey_nxt   = rkey_r;
    rtag_nxt   = rtag_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end
    if (cmd.load) begin
      item_nxt = in_data;
      ev_nxt   = 1'b0;
    end
    if (cmd.cur_ld) begin
      unique case (cmd.cur_src)
        CS_NEWEST: cur_nxt = newest_r;
        CS_OLDER:  cur_nxt = older_q;
        CS_OLDEST: cur_nxt = oldest_r;
        CS_CURSOR: cur_nxt = cursor_r;
        CS_FREEQ:  cur_nxt = free_q;
        default:   cur_nxt = NIL;
      endcase
    end
    if (cmd.cursor_ld) begin
      unique case (cmd.cursor_src)
        KS_NEWEST: cursor_nxt = newest_r;
        KS_OLDER:  cursor_nxt = older_q;
        KS_NIL:    cursor_nxt = NIL;
        default:   cursor_nxt = NIL;
      endcase
    end
    if (cmd.unlink) begin
      if (newer_q == NIL) begin
        newest_nxt = older_q;
      end
      if (older_q == NIL) begin
        oldest_nxt = newer_q;
      end
      if (cursor_r == cur_r) begin
        cursor_nxt = older_q;
      end
      if (held_r != '0) begin
        held_nxt = held_r - IW'(1);
      end
      if (cmd.free_slot) begin
        sp_nxt = sp_r + IW'(1);
      end
    end
    if (cmd.cnt_purge) begin
      if (cnt_stale) begin
        stale_nxt = stale_r + 32'd1;
      end else begin
        fresh_nxt = fresh_r + 32'd1;
      end
      if (cached_r != '0) begin
        cached_nxt = cached_r - 32'd1;
      end
    end
    if (cmd.evict_set) begin
      ev_nxt = 1'b1;
    end
    if (cmd.alloc) begin
      // fresh slots first, then recycle from the stack
      if (sts.fill_avail) begin
        cur_nxt  = fill_r;
        fill_nxt = fill_r + IW'(1);
      end else begin
        sp_nxt = sp_dec;
      end
    end
    if (cmd.push_b) begin
      newest_nxt = cur_r;
      if (newest_r == NIL) begin
        oldest_nxt = cur_r;
      end
      held_nxt = held_r + IW'(1);
    end
    if (cmd.upd_inc) begin
      upd_nxt = upd_r + 32'd1;
    end
    if (cmd.cached_inc) begin
      cached_nxt = cached_r + 32'd1;
    end
    if (cmd.res_ld) begin
      rstat_nxt = cmd.res_status;
      rkey_nxt  = (cmd.res_status == ST_RET) ? 32'(q_key) : 32'd0;
      rtag_nxt  = (cmd.res_status == ST_RET) ? q_tag : 32'd0;
    end
    if (cmd.out_ld) begin
      out_nxt.status         = rstat_r;
      out_nxt.evicted_oldest = ev_r;
      out_nxt.out_key        = rkey_r;
      out_nxt.out_tag        = rtag_r;
      out_nxt.entry_count    = 7'(held_r);
      out_nxt.total_cached   = cached_r;
      out_nxt.updated_total  = upd_r;
      out_nxt.purged_fresh   = fresh_r;
      out_nxt.purged_stale   = stale_r;
      ov_nxt                 = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '0;
      newest_r <= NIL;
      oldest_r <= NIL;
      cursor_r <= NIL;
      cur_r    <= NIL;
      fill_r   <= '0;
      sp_r     <= '0;
      held_r   <= '0;
      cached_r <= '0;
      upd_r    <= '0;
      fresh_r  <= '0;
      stale_r  <= '0;
      ev_r     <= 1'b0;
      rstat_r  <= ST_NEW;
      ov_r     <= 1'b0;
    end else begin
      limit_r  <= limit_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      cursor_r <= cursor_nxt;
      cur_r    <= cur_nxt;
      fill_r   <= fill_nxt;
      sp_r     <= sp_nxt;
      held_r   <= held_nxt;
      cached_r <= cached_nxt;
      upd_r    <= upd_nxt;
      fresh_r  <= fresh_nxt;
      stale_r  <= stale_nxt;
      ev_r     <= ev_nxt;
      rstat_r  <= rstat_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rkey_r <= rkey_nxt;
    rtag_r <= rtag_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0) == (newest_r == NIL))
    else $error("newest pointer disagrees with entry count");

  a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (newest_r == NIL) == (oldest_r == NIL))
    else $error("list ends disagree");

  a_stack_fill: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= fill_r)
    else $error("free stack deeper than slots handed out");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> ov_r)
    else $error("result word lost after load");
`endif

endmodule

/* rtl/keyed_expiring_entry_table_top.sv */
// ----------------------------------------------------------------------------
// keyed_expiring_entry_table_top
// Table of keyed entries kept newest to oldest, with expiry and purge.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command word (add, purge, iterate
//   first, iterate next); every accepted word yields exactly one result word
//   on out_valid/out_ready/out_data, in order.
//   cfg_we/cfg_wdata write entry_limit at once; write it while idle.
//   Steps: the word is loaded and dispatched, then
//     add     : a read and a check per entry searched (up to the held
//               count), a read and an unlink per eviction, then allocation and linking of the new entry
//     purge   : a read and a check per held entry
//     iterate : first loads the cursor, next steps it to the older entry;
//               each stale entry met on the way is read and dropped
//   and the result is loaded into the output register. The list walk reads
//   each entry through the registered read port of the entry stores.
//   The next word is taken as soon as the result sits in the output
//   register, even if the receiver has not yet taken it; a stalled receiver
//   holds the block in its final step of the next word.
//   Reset (rst_n low at a clock edge) empties the table, zeroes the counters
//   and the limit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_expiring_entry_table_top
  import kex_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  kex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kex_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the keyed expiring entry table against a behavioral list model:
// adds, purges and walks with random handshake gaps, several entry limits.
// ----------------------------------------------------------------------------
module tb;
  import kex_pkg::*;

  localparam int CAP = 64;
  localparam int NIL = CAP;
  localparam int WDOG_LIMIT = 200000;

  class table_scoreboard;
    bit          live [CAP];
    logic [31:0] key_q [CAP];
    logic [31:0] tag_q [CAP];
    logic [31:0] exp_q [CAP];
    bit          disc_q [CAP];
    int          older [CAP];
    int          newer [CAP];
    int          newest, oldest, cursor, held;
    logic [31:0] n_cached, n_upd, n_fresh, n_stale;
    logic [6:0]  limit;
    out_t        pending [$];
    int          errors;
    int          n_checked;

    function new();
      foreach (live[i]) live[i] = 0;
      newest = NIL; oldest = NIL; cursor = NIL; held = 0;
      n_cached = 0; n_upd = 0; n_fresh = 0; n_stale = 0;
      limit = 0; errors = 0; n_checked = 0;
    endfunction

    function bit stale(logic [31:0] e, logic [31:0] now);
      return e != 0 && e <= now;
    endfunction

    function void count_drop(logic [31:0] e, logic [31:0] now);
      if (stale(e, now)) n_stale++;
      else n_fresh++;
      if (n_cached != 0) n_cached--;
    endfunction

    function void unlink(int s);
      int o, n;
      o = older[s]; n = newer[s];
      if (n != NIL) older[n] = o; else newest = o;
      if (o != NIL) newer[o] = n; else oldest = n;
      if (cursor == s) cursor = o;
      live[s] = 0;
      if (held > 0) held--;
    endfunction

    function void link_front(int s);
      newer[s] = NIL;
      older[s] = newest;
      if (newest != NIL) newer[newest] = s; else oldest = s;
      newest = s;
      live[s] = 1;
      held++;
    endfunction

    // note an accepted input word and queue what it should produce
    function void note_input(in_t w);
      out_t r;
      int s, lim;
      r = '0;
      s = NIL;
      if (w.func == FN_ADD) begin
        for (int i = 0; i < CAP; i++)
          if (s == NIL && live[i] && key_q[i] == w.name_key) s = i;
        if (stale(w.expiry_time, w.now_time)) begin
          if (s != NIL) begin
            count_drop(w.expiry_time, w.now_time);
            unlink(s);
            r.status = ST_RMV;
          end else r.status = ST_IGN;
        end else if (s != NIL) begin
          unlink(s);
          tag_q[s] = w.data_tag; exp_q[s] = w.expiry_time; disc_q[s] = w.discard_mark;
          link_front(s);
          n_upd++;
          r.status = ST_UPD;
        end else begin
          lim = limit;
          if (lim == 0 || lim > CAP) lim = CAP;
          while (held >= lim && oldest != NIL) begin
            s = oldest;
            count_drop(exp_q[s], w.now_time);
            unlink(s);
            r.evicted_oldest = 1'b1;
          end
          s = NIL;
          for (int i = 0; i < CAP; i++)
            if (s == NIL && !live[i]) s = i;
          if (s != NIL) begin
            key_q[s] = w.name_key; tag_q[s] = w.data_tag;
            exp_q[s] = w.expiry_time; disc_q[s] = w.discard_mark;
            link_front(s);
          end
          n_cached++;
          r.status = ST_NEW;
        end
      end else if (w.func == FN_PURGE) begin
        int c, nx;
        c = newest;
        while (c != NIL) begin
          nx = older[c];
          if (disc_q[c] || exp_q[c] == 0 || stale(exp_q[c], w.now_time)) begin
            count_drop(exp_q[c], w.now_time);
            unlink(c);
          end
          c = nx;
        end
        cursor = NIL;
        r.status = ST_PURGE;
      end else begin
        if (w.func == FN_FIRST) cursor = newest;
        else if (cursor != NIL) cursor = older[cursor];
        // drop stale entries under the cursor
        while (cursor != NIL && stale(exp_q[cursor], w.now_time)) begin
          count_drop(exp_q[cursor], w.now_time);
          unlink(cursor);
        end
        if (cursor != NIL) begin
          r.status = ST_RET;
          r.out_key = key_q[cursor];
          r.out_tag = tag_q[cursor];
        end else r.status = ST_END;
      end
      r.entry_count = held[6:0];
      r.total_cached = n_cached;
      r.updated_total = n_upd;
      r.purged_fresh = n_fresh;
      r.purged_stale = n_stale;
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("tb: mismatch %s got %0h want %0h (result %0d)", what, got, want, n_checked);
      errors++;
    endtask

    task check_result(out_t g);
      out_t e;
      if (pending.size() == 0) begin
        report("unexpected result word, status", 32'(g.status), 32'd0);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", 32'(g.status), 32'(e.status));
      if (g.evicted_oldest !== e.evicted_oldest)
        report("evicted_oldest", 32'(g.evicted_oldest), 32'(e.evicted_oldest));
      if (g.out_key !== e.out_key) report("out_key", g.out_key, e.out_key);
      if (g.out_tag !== e.out_tag) report("out_tag", g.out_tag, e.out_tag);
      if (g.entry_count !== e.entry_count)
        report("entry_count", 32'(g.entry_count), 32'(e.entry_count));
      if (g.total_cached !== e.total_cached)
        report("total_cached", g.total_cached, e.total_cached);
      if (g.updated_total !== e.updated_total)
        report("updated_total", g.updated_total, e.updated_total);
      if (g.purged_fresh !== e.purged_fresh)
        report("purged_fresh", g.purged_fresh, e.purged_fresh);
      if (g.purged_stale !== e.purged_stale)
        report("purged_stale", g.purged_stale, e.purged_stale);
      n_checked++;
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  table_scoreboard sb;
  bit   quiet_tail;
  bit   hold_sink;
  int   idle_cycles;
  int   n_sent;
  logic [31:0] clock_now;

  keyed_expiring_entry_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0; cfg_we = 0; cfg_wdata = '0;
  end

  // result side: random stall bursts, a long hold when asked
  initial begin
    int gap;
    sb = new();
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_sink) out_ready <= 0;
      else if (!quiet_tail && out_ready && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        gap = $urandom_range(1, 7);
        repeat (gap) begin
          @(posedge clk);
        end
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back words; drop it only for a gap
  task send_word(in_t w);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w);
    n_sent++;
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_limit(logic [6:0] v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.limit = v;
  endtask

  function in_t make_word(logic [1:0] f, logic [31:0] k, logic [31:0] t,
                          logic [31:0] e, bit d, logic [31:0] now);
    in_t w;
    w.func = f; w.name_key = k; w.data_tag = t;
    w.expiry_time = e; w.discard_mark = d; w.now_time = now;
    return w;
  endfunction

  // random word: small key pool for hits, time near clock_now for staleness
  function in_t rand_word(int key_pool);
    in_t w;
    int pick;
    w.data_tag = $urandom;
    w.discard_mark = 1'($urandom_range(0, 1));
    w.name_key = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, key_pool);
    clock_now += $urandom_range(0, 3);
    w.now_time = ($urandom_range(0, 30) == 0) ? $urandom : clock_now;
    pick = $urandom_range(0, 19);
    if (pick < 11) w.func = FN_ADD;
    else if (pick < 12) w.func = FN_PURGE;
    else if (pick < 14) w.func = FN_FIRST;
    else w.func = FN_NEXT;
    case ($urandom_range(0, 5))
      0: w.expiry_time = 0;
      1: w.expiry_time = $urandom;
      2: w.expiry_time = clock_now - $urandom_range(0, 20);
      default: w.expiry_time = clock_now + $urandom_range(1, 60);
    endcase
    return w;
  endfunction

  initial begin
    logic [6:0] limits [5];
    limits = '{7'd1, 7'd64, 7'd127, 7'd5, 7'd0};
    n_sent = 0; quiet_tail = 0; hold_sink = 0; idle_cycles = 0; clock_now = 100;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, every function, the special cases
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 0));
    send_word(make_word(FN_FIRST, 0, 0, 0, 0, 0));
    send_word(make_word(FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 10));
    send_word(make_word(FN_ADD, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_word(make_word(FN_ADD, 7, 32'h55, 50, 0, 10));
    send_word(make_word(FN_ADD, 7, 32'hAA, 60, 1, 10));
    send_word(make_word(FN_ADD, 8, 32'h1, 20, 0, 10));
    send_word(make_word(FN_FIRST, 0, 0, 0, 0, 10));
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 30));
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 30));
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 30));
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 30));
    send_word(make_word(FN_ADD, 7, 0, 5, 0, 10));
    send_word(make_word(FN_ADD, 9, 0, 5, 0, 10));
    send_word(make_word(FN_ADD, 9, 3, 40, 0, 10));
    send_word(make_word(FN_PURGE, 0, 0, 0, 0, 45));
    send_word(make_word(FN_NEXT, 0, 0, 0, 0, 45));
    for (int i = 0; i < 6; i++)
      send_word(make_word(FN_ADD, 100 + i, i, 500 + i, 0, 10));
    // lower the limit below the held count
    write_limit(7'd2);
    send_word(make_word(FN_ADD, 200, 1, 502, 0, 501));
    send_word(make_word(FN_PURGE, 0, 0, 0, 0, 0));

    // sender keeps offering while the receiver holds off
    hold_sink = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_sink = 0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_word(rand_word(20));
    drain();

    // random phases over several limits, with a full drain between
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int i = 0; i < 160; i++) begin
        if (p == 4 && i >= 110) quiet_tail = 1;
        send_word(rand_word(p == 1 ? 90 : 24));
      end
      if (p == 2) begin
        // fill the table to its capacity with distinct fresh keys
        for (int i = 0; i < 66; i++)
          send_word(make_word(FN_ADD, 32'h8000_0000 + i, i, 0, 0, clock_now));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("tb: %0d words sent, %0d results checked over six limit settings",
             n_sent, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
